FILE: hw/rtl/nrd_pkg.sv
// Shared types and constants for the Nagumo reaction-diffusion right-hand side.
// Holds the port words, the job format passed from front to back, and the
// fixed-point formats. No dependencies.
package nrd_pkg;

  // Field formats.
  localparam int SAMPLE_BITS = 16;  // signed Q1.14 samples
  localparam int FRAC_BITS   = 14;
  localparam int CFG_BITS    = 16;  // unsigned Q8.8 registers
  localparam int CFG_FRAC    = 8;
  localparam int DERIV_BITS  = 32;  // signed Q17.14 result

  // A three-point Laplacian of SAMPLE_BITS samples needs two more bits.
  localparam int LAP_BITS = SAMPLE_BITS + 2;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_DX_SQUARED = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_REACTION_GAIN  = CFG_INDEX_BITS'(1);

  // Reset values of the registers: 25.0 and 1.0 in Q8.8.
  localparam logic [CFG_BITS-1:0] INV_DX_SQUARED_RESET = CFG_BITS'(6400);
  localparam logic [CFG_BITS-1:0] REACTION_GAIN_RESET  = CFG_BITS'(256);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } sample_word_t;

  typedef struct packed {
    logic signed [DERIV_BITS-1:0] derivative;
    logic                         last_result;
  } result_word_t;

  // One grid point to evaluate: its value, its Laplacian, and the end mark.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] point;
    logic signed [LAP_BITS-1:0]    lap;
    logic                          last;
  } job_t;

  // Jobs handed from the front to the queue in one cycle (zero, one or two).
  typedef struct packed {
    logic [1:0] count;
    job_t       first;
    job_t       second;
  } job_push_t;

  // Where the front stands within a grid line.
  typedef enum logic [2:0] {
    POS_START = 3'b001,
    POS_ONE   = 3'b010,
    POS_MANY  = 3'b100
  } line_pos_t;

endpackage

FILE: hw/rtl/nrd_front.sv
// Front end: accepts sample words, keeps the stencil window and turns each
// sample into zero, one or two jobs. Depends on nrd_pkg.
module nrd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  nrd_pkg::sample_word_t sample_data,
  input  logic                 room_for_two,
  output nrd_pkg::job_push_t   push
);

  localparam int LB = nrd_pkg::LAP_BITS;

  nrd_pkg::line_pos_t pos, pos_next;
  logic signed [nrd_pkg::SAMPLE_BITS-1:0] prev_sample, prev_sample_next;
  logic signed [nrd_pkg::SAMPLE_BITS-1:0] prev_prev_sample, prev_prev_sample_next;

  logic accept;
  logic signed [LB-1:0] s_x, p_x, pp_x, edge_diff, lap_first, lap_inner;

  assign sample_stall = !room_for_two;
  assign accept       = sample_valid && room_for_two;

  assign s_x  = LB'(sample_data.sample);
  assign p_x  = LB'(prev_sample);
  assign pp_x = LB'(prev_prev_sample);

  // Reflecting ends use twice the difference to the single neighbor.
  assign edge_diff = s_x - p_x;
  assign lap_first = edge_diff <<< 1;
  assign lap_inner = pp_x - (p_x <<< 1) + s_x;

  always_comb begin
    pos_next              = pos;
    prev_sample_next      = prev_sample;
    prev_prev_sample_next = prev_prev_sample;
    push.count            = 2'd0;
    push.first.point      = prev_sample;
    push.first.lap        = lap_inner;
    push.first.last       = 1'b0;
    push.second.point     = sample_data.sample;
    push.second.lap       = -lap_first;
    push.second.last      = 1'b1;
    if (accept) begin
      unique case (pos)
        nrd_pkg::POS_START: begin
          if (sample_data.last_sample) begin
            // A lone sample: reaction term only, so its Laplacian is zero.
            push.count       = 2'd1;
            push.first.point = sample_data.sample;
            push.first.lap   = '0;
            push.first.last  = 1'b1;
          end else begin
            prev_sample_next = sample_data.sample;
            pos_next         = nrd_pkg::POS_ONE;
          end
        end
        nrd_pkg::POS_ONE, nrd_pkg::POS_MANY: begin
          push.first.lap = (pos == nrd_pkg::POS_ONE) ? lap_first : lap_inner;
          if (sample_data.last_sample) begin
            push.count            = 2'd2;
            prev_sample_next      = '0;
            prev_prev_sample_next = '0;
            pos_next              = nrd_pkg::POS_START;
          end else begin
            push.count            = 2'd1;
            prev_prev_sample_next = prev_sample;
            prev_sample_next      = sample_data.sample;
            pos_next              = nrd_pkg::POS_MANY;
          end
        end
        default: begin
          pos_next = nrd_pkg::POS_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= nrd_pkg::POS_START;
      prev_sample      <= '0;
      prev_prev_sample <= '0;
    end else begin
      pos              <= pos_next;
      prev_sample      <= prev_sample_next;
      prev_prev_sample <= prev_prev_sample_next;
    end
  end

endmodule

FILE: hw/rtl/nrd_job_queue.sv
// Short job queue between front and back: up to two pushes and one pop per
// cycle, held in flip-flops. Depends on nrd_pkg.
module nrd_job_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  nrd_pkg::job_push_t push,
  output logic               room_for_two,
  output logic               job_valid,
  output nrd_pkg::job_t      job,
  input  logic               pop
);

  // DEPTH must be a power of two so the pointers wrap on their own.
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  nrd_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;

  assign room_for_two = count <= CNT_W'(DEPTH - 2);
  assign job_valid    = count != '0;
  assign job          = entries[rd_ptr];

  always_comb begin
    count_next = count + CNT_W'(push.count);
    if (pop) begin
      count_next = count_next - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

endmodule

FILE: hw/rtl/nrd_back.sv
// Back end: four-stage arithmetic pipeline that turns a job into a saturated
// derivative. Diffusion and reaction run side by side. Depends on nrd_pkg.
module nrd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_valid,
  input  nrd_pkg::job_t                job,
  output logic                         pop,
  input  logic [nrd_pkg::CFG_BITS-1:0] inv_dx_squared,
  input  logic [nrd_pkg::CFG_BITS-1:0] reaction_gain,
  output logic                         result_valid,
  input  logic                         result_stall,
  output nrd_pkg::result_word_t        result_data
);

  localparam int S  = nrd_pkg::SAMPLE_BITS;
  localparam int F  = nrd_pkg::FRAC_BITS;
  localparam int Q  = nrd_pkg::CFG_FRAC;
  localparam int CB = nrd_pkg::CFG_BITS;
  localparam int DB = nrd_pkg::DERIV_BITS;

  // Widths of the intermediates; a rounding shift by n of a W-bit value
  // leaves W + 1 - n bits. None of them comes near the 64-bit bound.
  localparam int DP_W  = nrd_pkg::LAP_BITS + CB + 1;
  localparam int D_W   = DP_W + 1 - Q;
  localparam int UU_W  = 2 * S;
  localparam int U2_W  = UU_W + 1 - F;
  localparam int OM_W  = S + 1;
  localparam int TP_W  = U2_W + OM_W;
  localparam int T_W   = TP_W + 1 - F;
  localparam int RP_W  = T_W + CB + 1;
  localparam int R_W   = RP_W + 1 - Q;
  localparam int SUM_W = R_W + 1;

  localparam logic signed [DP_W:0] DP_HALF = (DP_W + 1)'(1) <<< (Q - 1);
  localparam logic signed [UU_W:0] UU_HALF = (UU_W + 1)'(1) <<< (F - 1);
  localparam logic signed [TP_W:0] TP_HALF = (TP_W + 1)'(1) <<< (F - 1);
  localparam logic signed [RP_W:0] RP_HALF = (RP_W + 1)'(1) <<< (Q - 1);
  localparam logic signed [OM_W-1:0] ONE   = OM_W'(1) <<< F;

  logic adv;

  logic                   s1_valid, s1_last;
  logic signed [DP_W-1:0] s1_dprod;
  logic signed [UU_W-1:0] s1_uu;
  logic signed [OM_W-1:0] s1_om;

  logic                   s2_valid, s2_last;
  logic signed [D_W-1:0]  s2_d;
  logic signed [TP_W-1:0] s2_tprod;

  logic                   s3_valid, s3_last;
  logic signed [D_W-1:0]  s3_d;
  logic signed [RP_W-1:0] s3_rprod;

  logic signed [CB:0]     inv_s, gain_s;
  logic signed [DP_W:0]   d_sum;
  logic signed [UU_W:0]   u2_sum;
  logic signed [U2_W-1:0] u2;
  logic signed [TP_W:0]   t_sum;
  logic signed [T_W-1:0]  t;
  logic signed [RP_W:0]   r_sum;
  logic signed [R_W-1:0]  r;
  logic signed [SUM_W-1:0] total;
  logic signed [DB-1:0]   total_sat;

  // The whole pipeline holds while a finished result waits to be taken.
  assign adv = !(result_valid && result_stall);
  assign pop = job_valid && adv;

  assign inv_s  = $signed({1'b0, inv_dx_squared});
  assign gain_s = $signed({1'b0, reaction_gain});

  // Rounding shifts, nearest with ties toward plus infinity.
  assign d_sum  = (DP_W + 1)'(s1_dprod) + DP_HALF;
  assign u2_sum = (UU_W + 1)'(s1_uu) + UU_HALF;
  assign u2     = u2_sum[UU_W:F];
  assign t_sum  = (TP_W + 1)'(s2_tprod) + TP_HALF;
  assign t      = t_sum[TP_W:F];
  assign r_sum  = (RP_W + 1)'(s3_rprod) + RP_HALF;
  assign r      = r_sum[RP_W:Q];

  assign total = SUM_W'(s3_d) + SUM_W'(r);

  always_comb begin
    if (&total[SUM_W-1:DB-1] || !(|total[SUM_W-1:DB-1])) begin
      total_sat = total[DB-1:0];
    end else if (total[SUM_W-1]) begin
      total_sat = {1'b1, {(DB - 1){1'b0}}};
    end else begin
      total_sat = {1'b0, {(DB - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= job_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

  // Operands are sign-extended to the product width before each multiply.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dprod <= DP_W'(job.lap) * DP_W'(inv_s);
      s1_uu    <= UU_W'(job.point) * UU_W'(job.point);
      s1_om    <= ONE - OM_W'(job.point);
      s1_last  <= job.last;

      s2_d     <= d_sum[DP_W:Q];
      s2_tprod <= TP_W'(u2) * TP_W'(s1_om);
      s2_last  <= s1_last;

      s3_d     <= s2_d;
      s3_rprod <= RP_W'(t) * RP_W'(gain_s);
      s3_last  <= s2_last;

      result_data.derivative  <= total_sat;
      result_data.last_result <= s3_last;
    end
  end

endmodule

FILE: hw/rtl/nagumo_reaction_diffusion_rhs.sv
// Top level of the Nagumo reaction-diffusion right-hand side: configuration
// registers, front end, job queue and arithmetic back end.
// Depends on nrd_pkg, nrd_front, nrd_job_queue and nrd_back.
//
//   Channel  Signals                                  Word
//   sample   sample_valid, sample_stall, sample_data  sample, last_sample
//   result   result_valid, result_stall, result_data  derivative, last_result
//   config   cfg_we, cfg_index, cfg_data              16-bit register value
//
// A sample word can be taken every cycle while the job queue has room for
// two jobs; the back end delivers one result per cycle while jobs wait and
// no result stalls, so a line of n samples yields n results. A result passes
// the multiply and round stages s1, s2, s3 and then the result register once
// its job leaves the queue head. Reset clears the stencil window, queue and
// pipeline and restores both registers. A stalled result holds the whole
// back end; the queue keeps taking jobs until it is nearly full.
module nagumo_reaction_diffusion_rhs #(
  parameter int JOB_QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  nrd_pkg::sample_word_t              sample_data,
  output logic                               result_valid,
  input  logic                               result_stall,
  output nrd_pkg::result_word_t              result_data,
  input  logic                               cfg_we,
  input  logic [nrd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [nrd_pkg::CFG_BITS-1:0]       cfg_data
);

  logic [nrd_pkg::CFG_BITS-1:0] inv_dx_squared;
  logic [nrd_pkg::CFG_BITS-1:0] reaction_gain;

  nrd_pkg::job_push_t push;
  nrd_pkg::job_t      job;
  logic               room_for_two;
  logic               job_valid;
  logic               pop;

  // Register writes to indexes outside the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_dx_squared <= nrd_pkg::INV_DX_SQUARED_RESET;
      reaction_gain  <= nrd_pkg::REACTION_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nrd_pkg::REG_INV_DX_SQUARED: inv_dx_squared <= cfg_data;
        nrd_pkg::REG_REACTION_GAIN:  reaction_gain  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front turns each sample into jobs: none for the first sample of a
  // longer line, one per interior or lone sample, two for a marked last one.
  nrd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_data  (sample_data),
    .room_for_two (room_for_two),
    .push         (push)
  );

  nrd_job_queue #(
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room_for_two (room_for_two),
    .job_valid    (job_valid),
    .job          (job),
    .pop          (pop)
  );

  nrd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (job_valid),
    .job            (job),
    .pop            (pop),
    .inv_dx_squared (inv_dx_squared),
    .reaction_gain  (reaction_gain),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result_data    (result_data)
  );

endmodule
